// ----- hdl/ckmt_pkg.sv -----
// Shared constants and types for the checkerboard memory test sequencer.
`timescale 1ns / 1ps
`default_nettype none

package ckmt_pkg;

  // Memory size in bytes, as a power of two
  localparam int MEM_BYTES_LOG2 = 17;

  // Derived widths
  localparam int ADDR_W = MEM_BYTES_LOG2;      // byte address
  localparam int IDX_W  = MEM_BYTES_LOG2 - 1;  // position within one half
  localparam int LVL_W  = 5;                   // block level, j = 2^level
  localparam int DATA_W = 16;
  localparam int ERR_W  = 32;
  localparam int PASS_W = 16;

  // Packed beat widths
  localparam int S_TDATA_W = 16;
  localparam int M_FIELDS_W = 1 + ADDR_W + DATA_W + 1 + ERR_W + 1 + PASS_W + 1;
  localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  // Register defaults and masks
  localparam logic [DATA_W-1:0] PATTERN_RESET = 16'hA0A0;
  localparam logic [DATA_W-1:0] BYTE_MASK     = 16'h00FF;
  localparam logic [DATA_W-1:0] WORD_MASK     = 16'hFFFF;
  localparam logic [PASS_W-1:0] PASS_RESET    = 16'd1;

  // Configuration register index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_WORD_MODE    = 2'd0,
    REG_TEST_PATTERN = 2'd1,
    REG_PASS_COUNT   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  // Input command
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// ----- hdl/checker_memory_test_sequencer.sv -----
// Checkerboard memory test sequencer: access generation, readback compare, APB registers.
//
//  channel | direction | beat contents
//  s_*     | in        | tuser: opcode; tdata: read_data
//  m_*     | out       | tuser: is_write; tdata: access_valid, byte_address, access_data,
//          |           |   mismatch, error_total, pass_done, pass_number, test_done
//  apb     | in        | word_mode @0x0, test_pattern @0x4, pass_count @0x8
//
// One beat in, one beat out; a beat is accepted every cycle while the output
// register is empty or being drained. The result is registered: the position step,
// readback compare and address forming all sit between the state registers and
// the output register. rst clears all state and the registers to their defaults.
// A stall on m_tready holds the output beat and blocks s_tready.
`timescale 1ns / 1ps
`default_nettype none

module checker_memory_test_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ckmt_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] read_data
  input  wire logic                             s_tuser,  // [0] opcode
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] access_valid, [17:1] byte_address, [33:18] access_data, [34] mismatch,
  // [66:35] error_total, [67] pass_done, [83:68] pass_number, [84] test_done
  output logic [ckmt_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                  m_tuser,  // [0] is_write
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [3:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int ADDR_W = ckmt_pkg::ADDR_W;
  localparam int IDX_W  = ckmt_pkg::IDX_W;
  localparam int LVL_W  = ckmt_pkg::LVL_W;
  localparam int DATA_W = ckmt_pkg::DATA_W;
  localparam int ERR_W  = ckmt_pkg::ERR_W;
  localparam int PASS_W = ckmt_pkg::PASS_W;

  // Configuration registers
  logic              word_mode;
  logic [DATA_W-1:0] test_pattern;
  logic [PASS_W-1:0] pass_count;

  // Sequencer state
  logic              running;
  logic              finished;
  logic [PASS_W-1:0] pass_index;
  logic [LVL_W-1:0]  block_level;
  logic              check_phase;
  logic              odd_half;
  logic [IDX_W-1:0]  element_index;
  logic [ERR_W-1:0]  error_count;

  logic              running_next;
  logic              finished_next;
  logic [PASS_W-1:0] pass_index_next;
  logic [LVL_W-1:0]  block_level_next;
  logic              check_phase_next;
  logic              odd_half_next;
  logic [IDX_W-1:0]  element_index_next;
  logic [ERR_W-1:0]  error_count_next;

  // Result fields
  logic              access_valid;
  logic              is_write;
  logic [ADDR_W-1:0] byte_address;
  logic [DATA_W-1:0] access_data;
  logic              mismatch;
  logic              pass_done;

  logic                        in_accept;
  ckmt_pkg::opcode_t           opcode;
  logic [DATA_W-1:0]           read_data;
  ckmt_pkg::reg_index_t        reg_sel;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign opcode    = ckmt_pkg::opcode_t'(s_tuser);
  assign read_data = s_tdata[DATA_W-1:0];
  assign reg_sel   = ckmt_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode    <= 1'b0;
      test_pattern <= ckmt_pkg::PATTERN_RESET;
      pass_count   <= ckmt_pkg::PASS_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        ckmt_pkg::REG_WORD_MODE:    word_mode    <= pwdata[0];
        ckmt_pkg::REG_TEST_PATTERN: test_pattern <= pwdata[DATA_W-1:0];
        ckmt_pkg::REG_PASS_COUNT:   pass_count   <= pwdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (reg_sel)
      ckmt_pkg::REG_WORD_MODE:    prdata = {31'd0, word_mode};
      ckmt_pkg::REG_TEST_PATTERN: prdata = {{(32-DATA_W){1'b0}}, test_pattern};
      ckmt_pkg::REG_PASS_COUNT:   prdata = {{(32-PASS_W){1'b0}}, pass_count};
      default:                    prdata = 32'd0;
    endcase
  end

  // Mode-dependent sizes and the expected value at the current position
  logic [LVL_W-1:0]  elem_log2;
  logic [IDX_W:0]    half_size;
  logic [DATA_W-1:0] data_mask;
  logic [DATA_W-1:0] expected_now;
  logic [IDX_W:0]    index_inc;
  logic [LVL_W-1:0]  level_inc;
  logic [PASS_W-1:0] pass_inc;

  assign elem_log2 = word_mode ? LVL_W'(ckmt_pkg::MEM_BYTES_LOG2 - 1)
                               : LVL_W'(ckmt_pkg::MEM_BYTES_LOG2);
  assign half_size = (IDX_W+1)'(1) << (elem_log2 - LVL_W'(1));
  assign data_mask = word_mode ? ckmt_pkg::WORD_MASK : ckmt_pkg::BYTE_MASK;
  assign expected_now = (odd_half ? ~test_pattern : test_pattern) & data_mask;
  assign index_inc = {1'b0, element_index} + (IDX_W+1)'(1);
  assign level_inc = block_level + LVL_W'(1);
  assign pass_inc  = pass_index + PASS_W'(1);

  // Next state: start, or readback check plus one position step; idle advances hold
  always_comb begin
    running_next       = running;
    finished_next      = finished;
    pass_index_next    = pass_index;
    block_level_next   = block_level;
    check_phase_next   = check_phase;
    odd_half_next      = odd_half;
    element_index_next = element_index;
    error_count_next   = error_count;
    mismatch           = 1'b0;
    pass_done          = 1'b0;
    if (opcode == ckmt_pkg::OP_START) begin
      error_count_next   = '0;
      pass_index_next    = '0;
      block_level_next   = '0;
      check_phase_next   = 1'b0;
      odd_half_next      = 1'b0;
      element_index_next = '0;
      running_next       = (pass_count != '0);
      finished_next      = (pass_count == '0);
    end else if (running) begin
      // compare the read just completed
      if (check_phase && ((read_data & data_mask) != expected_now)) begin
        mismatch = 1'b1;
        if (error_count != '1) begin
          error_count_next = error_count + ERR_W'(1);
        end
      end
      // position step: element, half, phase, level, pass
      if (index_inc < half_size) begin
        element_index_next = index_inc[IDX_W-1:0];
      end else begin
        element_index_next = '0;
        if (!odd_half) begin
          odd_half_next = 1'b1;
        end else begin
          odd_half_next = 1'b0;
          if (!check_phase) begin
            check_phase_next = 1'b1;
          end else begin
            check_phase_next = 1'b0;
            if (level_inc < elem_log2) begin
              block_level_next = level_inc;
            end else begin
              block_level_next = '0;
              pass_done        = 1'b1;
              pass_index_next  = pass_inc;
              if (pass_inc >= pass_count || pass_inc == '0) begin
                running_next  = 1'b0;
                finished_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Access forming from the new position: split index around the level bit
  logic [ADDR_W:0] low_mask;
  logic [ADDR_W:0] index_ext;
  logic [ADDR_W:0] element_addr;
  logic [ADDR_W:0] scaled_addr;

  assign low_mask  = ~({(ADDR_W+1){1'b1}} << block_level_next);
  assign index_ext = (ADDR_W+1)'(element_index_next);
  assign element_addr = ((index_ext & ~low_mask) << 1)
                      | ((ADDR_W+1)'(odd_half_next) << block_level_next)
                      | (index_ext & low_mask);
  assign scaled_addr = word_mode ? (element_addr << 1) : element_addr;

  always_comb begin
    access_valid = running_next;
    is_write     = 1'b0;
    byte_address = '0;
    access_data  = '0;
    if (running_next) begin
      is_write     = !check_phase_next;
      byte_address = scaled_addr[ADDR_W-1:0];
      access_data  = (odd_half_next ? ~test_pattern : test_pattern) & data_mask;
    end
  end

  // State update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      finished      <= 1'b0;
      pass_index    <= '0;
      block_level   <= '0;
      check_phase   <= 1'b0;
      odd_half      <= 1'b0;
      element_index <= '0;
      error_count   <= '0;
    end else if (in_accept) begin
      running       <= running_next;
      finished      <= finished_next;
      pass_index    <= pass_index_next;
      block_level   <= block_level_next;
      check_phase   <= check_phase_next;
      odd_half      <= odd_half_next;
      element_index <= element_index_next;
      error_count   <= error_count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tuser <= is_write;
      m_tdata <= ckmt_pkg::M_TDATA_W'({finished_next, pass_index_next, pass_done,
                                       error_count_next, mismatch, access_data,
                                       byte_address, access_valid});
    end
  end

endmodule

`default_nettype wire
